/* design/esc_strip_pkg.sv */
// shared types, constants and step decode for the escape sequence stripper
`timescale 1ns / 1ps

package esc_strip_pkg;

  // holding store geometry
  localparam int HOLD_DEPTH = 32;
  localparam int CNT_W      = $clog2(HOLD_DEPTH + 1);
  localparam int ADDR_W     = $clog2(HOLD_DEPTH);

  // character codes
  localparam logic [7:0] CH_ESC  = 8'h1B;
  localparam logic [7:0] CH_BEL  = 8'h07;
  localparam logic [7:0] CH_OSC  = 8'h5D;
  localparam logic [7:0] CH_CSI  = 8'h5B;
  localparam logic [7:0] CH_BSL  = 8'h5C;
  localparam logic [7:0] CH_DCS  = 8'h50;
  localparam logic [7:0] CH_PM   = 8'h5E;
  localparam logic [7:0] CH_APC  = 8'h5F;
  localparam logic [7:0] FE_LO   = 8'h40;
  localparam logic [7:0] FE_HI   = 8'h5A;
  localparam logic [7:0] FIN_HI  = 8'h7E;
  localparam logic [7:0] PAR_LO  = 8'h30;
  localparam logic [7:0] PAR_HI  = 8'h3F;
  localparam logic [7:0] INT_LO  = 8'h20;
  localparam logic [7:0] INT_HI  = 8'h2F;

  // parser mode
  typedef enum logic [2:0] {
    MODE_NORMAL    = 3'd0,
    MODE_AFTER_ESC = 3'd1,
    MODE_OSC       = 3'd2,
    MODE_OSC_ESC   = 3'd3,
    MODE_CSI_PARAM = 3'd4,
    MODE_CSI_INTER = 3'd5
  } mode_t;

  // outcome of one parse step on a byte
  typedef enum logic [1:0] {
    ACT_HOLD   = 2'd0,
    ACT_FINISH = 2'd1,
    ACT_EMIT   = 2'd2,
    ACT_FAIL   = 2'd3
  } act_t;

  typedef struct packed {
    act_t  act;
    mode_t mode_nxt;
  } step_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE = 3'd0,
    ST_FAIL = 3'd1,
    ST_RD   = 3'd2,
    ST_EMIT = 3'd3,
    ST_STEP = 3'd4,
    ST_EOS  = 3'd5,
    ST_DONE = 3'd6
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic sel_cur;      // decode the latched byte instead of the port
    logic latch;        // capture the request
    logic do_hold;      // store byte, bump count, take new mode
    logic do_finish;    // drop the escape, back to normal
    logic out_direct;   // byte straight to output, last set
    logic fail_setup;   // set up replay range of held bytes
    logic rd_issue;     // read held byte at replay index
    logic emit_rd;      // emit byte read from store
    logic fail_finish;  // close replay, keep trailing ESC if any
    logic emit_cur;     // emit latched byte
    logic pend_flush;   // last byte of request to output, last set
  } ctl_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    act_t act;
    logic mode_normal;
    logic more;
    logic pend_v;
    logic slot_free;
    logic in_eos;
    logic cur_eos;
  } ctl_sts_t;

  function automatic logic is_fe(logic [7:0] b);
    return (b >= FE_LO && b <= FE_HI) || (b >= CH_BSL && b <= CH_APC);
  endfunction

  function automatic logic is_intro(logic [7:0] b);
    return b == CH_OSC || b == CH_DCS || b == CH_PM || b == CH_APC;
  endfunction

  function automatic logic is_param(logic [7:0] b);
    return b >= PAR_LO && b <= PAR_HI;
  endfunction

  function automatic logic is_inter(logic [7:0] b);
    return b >= INT_LO && b <= INT_HI;
  endfunction

  function automatic logic is_final(logic [7:0] b);
    return b >= FE_LO && b <= FIN_HI;
  endfunction

  // one parse step: what the byte does in the given mode
  function automatic step_t step_decode(mode_t mode, logic [7:0] b, logic full);
    step_t s;
    s.act      = ACT_FAIL;
    s.mode_nxt = mode;
    unique case (mode)
      MODE_AFTER_ESC: begin
        if (is_intro(b) || b == CH_CSI) begin
          s.act      = full ? ACT_FAIL : ACT_HOLD;
          s.mode_nxt = (b == CH_CSI) ? MODE_CSI_PARAM : MODE_OSC;
        end else if (is_fe(b)) begin
          s.act = ACT_FINISH;
        end
      end
      MODE_OSC: begin
        if (b == CH_BEL) begin
          s.act = ACT_FINISH;
        end else begin
          s.act      = full ? ACT_FAIL : ACT_HOLD;
          s.mode_nxt = (b == CH_ESC) ? MODE_OSC_ESC : MODE_OSC;
        end
      end
      MODE_OSC_ESC: begin
        if (b == CH_BSL) s.act = ACT_FINISH;
      end
      MODE_CSI_PARAM, MODE_CSI_INTER: begin
        if ((mode == MODE_CSI_PARAM && is_param(b)) || is_inter(b)) begin
          s.act      = full ? ACT_FAIL : ACT_HOLD;
          s.mode_nxt = is_inter(b) ? MODE_CSI_INTER : mode;
        end else if (is_final(b)) begin
          s.act = ACT_FINISH;
        end
      end
      default: begin
        if (b == CH_ESC) begin
          s.act      = ACT_HOLD;
          s.mode_nxt = MODE_AFTER_ESC;
        end else begin
          s.act      = ACT_EMIT;
          s.mode_nxt = MODE_NORMAL;
        end
      end
    endcase
    return s;
  endfunction

endpackage

/* design/esc_strip_dpath.sv */
// datapath: parse mode, holding store, replay index, look-ahead byte and output register
`timescale 1ns / 1ps

module esc_strip_dpath
  import esc_strip_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_kind,
  input  logic [7:0] in_byte,
  input  logic       out_ready,
  output logic       out_valid,
  output logic [7:0] out_byte,
  output logic       out_last,
  input  ctl_cmd_t   cmd,
  output ctl_sts_t   sts
);

  logic [7:0]       mem [HOLD_DEPTH];
  logic [7:0]       rd_data_r;
  mode_t            mode_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] idx_r;
  logic [CNT_W-1:0] end_r;
  logic             trail_r;
  logic [7:0]       cur_byte_r;
  logic             cur_kind_r;
  logic             pend_v_r;
  logic [7:0]       pend_byte_r;
  logic             out_valid_r;
  logic [7:0]       out_byte_r;
  logic             out_last_r;

  logic [7:0]       sel_byte;
  logic [7:0]       emit_byte;
  logic             full;
  logic             is_osc;
  logic             is_trail;
  logic             out_load;
  logic             emit_any;
  step_t            step;

  // decode of the byte under work
  always_comb begin
    sel_byte  = cmd.sel_cur ? cur_byte_r : in_byte;
    full      = (count_r == CNT_W'(HOLD_DEPTH));
    step      = step_decode(mode_r, sel_byte, full);
    is_osc    = (mode_r == MODE_OSC) || (mode_r == MODE_OSC_ESC);
    is_trail  = (mode_r == MODE_OSC_ESC);
    emit_any  = cmd.emit_rd | cmd.emit_cur;
    emit_byte = cmd.emit_rd ? rd_data_r : cur_byte_r;
    out_load  = cmd.out_direct | cmd.pend_flush | (emit_any & pend_v_r);
  end

  // status to controller
  always_comb begin
    sts.act         = step.act;
    sts.mode_normal = (mode_r == MODE_NORMAL);
    sts.more        = (idx_r < end_r);
    sts.pend_v      = pend_v_r;
    sts.slot_free   = !out_valid_r || out_ready;
    sts.in_eos      = in_kind;
    sts.cur_eos     = cur_kind_r;
  end

  // holding store, registered read
  always_ff @(posedge clk) begin
    if (cmd.do_hold) mem[count_r[ADDR_W-1:0]] <= sel_byte;
    if (cmd.rd_issue) rd_data_r <= mem[idx_r[ADDR_W-1:0]];
  end

  // parse mode and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_NORMAL;
      count_r <= '0;
    end else if (cmd.do_hold) begin
      mode_r  <= step.mode_nxt;
      count_r <= count_r + CNT_W'(1);
    end else if (cmd.do_finish) begin
      mode_r  <= MODE_NORMAL;
      count_r <= '0;
    end else if (cmd.fail_finish) begin
      mode_r  <= trail_r ? MODE_AFTER_ESC : MODE_NORMAL;
      count_r <= trail_r ? CNT_W'(1) : '0;
    end
  end

  // replay range, latched request
  always_ff @(posedge clk) begin
    if (cmd.fail_setup) begin
      idx_r   <= is_osc ? CNT_W'(2) : '0;
      end_r   <= count_r - CNT_W'(is_trail && count_r != '0);
      trail_r <= is_trail;
    end else if (cmd.emit_rd) begin
      idx_r <= idx_r + CNT_W'(1);
    end
    if (cmd.latch) begin
      cur_byte_r <= in_byte;
      cur_kind_r <= in_kind;
    end
  end

  // look-ahead byte, so that the last flag lands on the right result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
    end else if (emit_any) begin
      pend_v_r <= 1'b1;
    end else if (cmd.pend_flush) begin
      pend_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_any) pend_byte_r <= emit_byte;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_byte_r <= cmd.out_direct ? sel_byte : pend_byte_r;
      out_last_r <= cmd.out_direct | cmd.pend_flush;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

endmodule

/* design/esc_strip_ctrl.sv */
// controller: request acceptance, escape failure replay and end-of-request sequencing
`timescale 1ns / 1ps

module esc_strip_ctrl
  import esc_strip_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  ctl_sts_t sts,
  output ctl_cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = sts.slot_free;
        if (in_valid && sts.slot_free) begin
          if (sts.in_eos) begin
            if (sts.mode_normal) begin
              cmd.do_finish = 1'b1;
            end else begin
              cmd.latch = 1'b1;
              state_nxt = ST_FAIL;
            end
          end else begin
            unique case (sts.act)
              ACT_HOLD:   cmd.do_hold    = 1'b1;
              ACT_FINISH: cmd.do_finish  = 1'b1;
              ACT_EMIT:   cmd.out_direct = 1'b1;
              ACT_FAIL: begin
                cmd.latch = 1'b1;
                state_nxt = ST_FAIL;
              end
            endcase
          end
        end
      end
      ST_FAIL: begin
        cmd.fail_setup = 1'b1;
        state_nxt      = ST_RD;
      end
      // read next held byte, or close the replay and go on
      ST_RD: begin
        if (sts.more) begin
          cmd.rd_issue = 1'b1;
          state_nxt    = ST_EMIT;
        end else begin
          cmd.fail_finish = 1'b1;
          state_nxt       = sts.cur_eos ? ST_EOS : ST_STEP;
        end
      end
      ST_EMIT: begin
        if (!sts.pend_v || sts.slot_free) begin
          cmd.emit_rd = 1'b1;
          state_nxt   = ST_RD;
        end
      end
      // reprocess the failing byte in the new mode
      ST_STEP: begin
        cmd.sel_cur = 1'b1;
        unique case (sts.act)
          ACT_HOLD: begin
            cmd.do_hold = 1'b1;
            state_nxt   = ST_DONE;
          end
          ACT_FINISH: begin
            cmd.do_finish = 1'b1;
            state_nxt     = ST_DONE;
          end
          ACT_EMIT: begin
            if (!sts.pend_v || sts.slot_free) begin
              cmd.emit_cur = 1'b1;
              state_nxt    = ST_DONE;
            end
          end
          ACT_FAIL: state_nxt = ST_FAIL;
        endcase
      end
      ST_EOS: begin
        if (sts.mode_normal) begin
          cmd.do_finish = 1'b1;
          state_nxt     = ST_DONE;
        end else begin
          state_nxt = ST_FAIL;
        end
      end
      ST_DONE: begin
        if (!sts.pend_v) begin
          state_nxt = ST_IDLE;
        end else if (sts.slot_free) begin
          cmd.pend_flush = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

/* design/ansi_escape_stripper.sv */
// top level of the ansi escape sequence stripper
//
// Input channel (in_valid/in_ready): one request per data byte (in_kind 0,
// in_byte) or an end-of-stream marker (in_kind 1). Output channel
// (out_valid/out_ready): stripped text bytes, out_last set on the final
// byte that a request produces; a request may produce none.
// Plain text, escape bytes that extend or close an escape, and an
// end-of-stream with no open escape go at one request per cycle while the
// output register is free; the text byte is in it on the next cycle.
// A failed escape replays its held bytes from the 32-entry store, each
// one read from the store and then emitted, between setup and wrap-up
// states; a full store replays up to 32 bytes.
// Requests are taken only while the output register is free or being
// drained, so a stalled receiver holds off new requests; no result is
// lost or dropped.
// Reset clears the parse mode, fill count and output valid; the store
// contents are not cleared and need no clearing pass.
`timescale 1ns / 1ps

module ansi_escape_stripper
  import esc_strip_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_kind,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  // sequencing
  esc_strip_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // storage and output
  esc_strip_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_kind   (in_kind),
    .in_byte   (in_byte),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_byte  (out_byte),
    .out_last  (out_last),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

/* bench/ansi_escape_stripper_tb.sv */
// testbench for the ansi escape stripper: directed and random requests checked against a predictor
`timescale 1ns / 1ps

module ansi_escape_stripper_tb
  import esc_strip_pkg::*;
();

  localparam int EOS_MARK    = 256;     // stands for an end-of-stream request in a burst
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 100;    // extra wait after the last expected byte, so that stray bytes still show
  localparam int HOLD_CYCLES = 150;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } text_res_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       in_kind = 1'b0;
  logic [7:0] in_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       out_last;

  // predictor state
  mode_t      pmode = MODE_NORMAL;
  logic [7:0] held [HOLD_DEPTH];
  int         held_n = 0;
  logic [7:0] item_text[$];
  text_res_t  expected_text[$];

  int burst[$];
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_token = 0;

  int errors = 0;
  int cycles = 0;
  int items_sent = 0;
  int eos_sent = 0;
  int results_checked = 0;
  int aborts = 0;
  int overflow_fails = 0;

  ansi_escape_stripper uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_kind  (in_kind),
    .in_byte  (in_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_byte (out_byte),
    .out_last (out_last)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, expected_text.size());
      $display("FAIL");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin : receiver
    int hold_left;
    int hold_seen;
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // compare each accepted text byte with the oldest expectation
  always @(posedge clk) begin : check_text
    text_res_t e;
    if (rst_n && out_valid && out_ready) begin
      results_checked++;
      if (expected_text.size() == 0) begin
        $display("%0t: unexpected byte %h last %b, nothing expected", $time, out_byte, out_last);
        errors++;
      end else begin
        e = expected_text.pop_front();
        if (out_byte !== e.data) begin
          $display("%0t: out_byte expected %h, got %h", $time, e.data, out_byte);
          errors++;
        end
        if (out_last !== e.last) begin
          $display("%0t: out_last expected %b, got %b (byte %h)", $time, e.last, out_last,
                   out_byte);
          errors++;
        end
      end
    end
  end

  // byte classes
  function automatic bit fe_final(logic [7:0] b);
    return (b >= 8'h40 && b <= 8'h5A) || (b >= 8'h5C && b <= 8'h5F);
  endfunction

  function automatic bit string_intro(logic [7:0] b);
    return b == CH_OSC || b == CH_DCS || b == CH_PM || b == CH_APC;
  endfunction

  function automatic bit csi_param(logic [7:0] b);
    return b >= 8'h30 && b <= 8'h3F;
  endfunction

  function automatic bit csi_mid(logic [7:0] b);
    return b >= 8'h20 && b <= 8'h2F;
  endfunction

  function automatic bit csi_final(logic [7:0] b);
    return b >= 8'h40 && b <= 8'h7E;
  endfunction

  // store a byte of the open escape; refuses when the store is full
  function automatic bit try_hold(logic [7:0] b);
    if (held_n >= HOLD_DEPTH) begin
      overflow_fails++;
      return 1'b0;
    end
    held[held_n] = b;
    held_n++;
    return 1'b1;
  endfunction

  // give up the open escape: strings give back only their content
  task automatic abort_escape();
    bit trail;
    int upto;
    aborts++;
    if (pmode == MODE_OSC || pmode == MODE_OSC_ESC) begin
      trail = (pmode == MODE_OSC_ESC);
      upto = held_n;
      if (trail && upto > 0) upto--;
      for (int i = 2; i < upto; i++) item_text = {item_text, held[i]};
      if (trail) begin
        held[0] = CH_ESC;
        held_n = 1;
        pmode = MODE_AFTER_ESC;
      end else begin
        held_n = 0;
        pmode = MODE_NORMAL;
      end
    end else begin
      for (int i = 0; i < held_n; i++) item_text = {item_text, held[i]};
      held_n = 0;
      pmode = MODE_NORMAL;
    end
  endtask

  // one data byte through the parser; a failing byte is parsed again
  task automatic feed_byte(logic [7:0] b);
    bit again;
    again = 1'b1;
    while (again) begin
      again = 1'b0;
      case (pmode)
        MODE_AFTER_ESC: begin
          if (string_intro(b) || b == CH_CSI) begin
            if (try_hold(b)) pmode = (b == CH_CSI) ? MODE_CSI_PARAM : MODE_OSC;
            else begin
              abort_escape();
              again = 1'b1;
            end
          end else if (fe_final(b)) begin
            held_n = 0;
            pmode = MODE_NORMAL;
          end else begin
            abort_escape();
            again = 1'b1;
          end
        end
        MODE_OSC: begin
          if (b == CH_BEL) begin
            held_n = 0;
            pmode = MODE_NORMAL;
          end else if (try_hold(b)) begin
            if (b == CH_ESC) pmode = MODE_OSC_ESC;
          end else begin
            abort_escape();
            again = 1'b1;
          end
        end
        MODE_OSC_ESC: begin
          if (b == CH_BSL) begin
            held_n = 0;
            pmode = MODE_NORMAL;
          end else begin
            abort_escape();
            again = 1'b1;
          end
        end
        MODE_CSI_PARAM, MODE_CSI_INTER: begin
          if ((pmode == MODE_CSI_PARAM && csi_param(b)) || csi_mid(b)) begin
            if (try_hold(b)) begin
              if (csi_mid(b)) pmode = MODE_CSI_INTER;
            end else begin
              abort_escape();
              again = 1'b1;
            end
          end else if (csi_final(b)) begin
            held_n = 0;
            pmode = MODE_NORMAL;
          end else begin
            abort_escape();
            again = 1'b1;
          end
        end
        default: begin
          if (b == CH_ESC) begin
            held[0] = CH_ESC;
            held_n = 1;
            pmode = MODE_AFTER_ESC;
          end else begin
            pmode = MODE_NORMAL;
            item_text = {item_text, b};
          end
        end
      endcase
    end
  endtask

  // expected text for one accepted request
  task automatic predict_stripped_text(logic kind, logic [7:0] b);
    text_res_t r;
    item_text.delete();
    if (kind) begin
      while (pmode != MODE_NORMAL) abort_escape();
      held_n = 0;
    end else begin
      feed_byte(b);
    end
    foreach (item_text[i]) begin
      r.data = item_text[i];
      r.last = (i == item_text.size() - 1);
      expected_text = {expected_text, r};
    end
  endtask

  // offer one request and wait for it to be taken
  task automatic send_item(logic kind, logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind  <= kind;
    in_byte  <= b;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (kind) eos_sent++;
    predict_stripped_text(kind, b);
  endtask

  task automatic send_burst();
    int v;
    foreach (burst[i]) begin
      v = burst[i];
      if (v == EOS_MARK) send_item(1'b1, 8'($urandom_range(255)));
      else send_item(1'b0, v[7:0]);
    end
  endtask

  // append one entry to the burst
  task automatic burst_add(int v);
    burst = {burst, v};
  endtask

  function automatic logic [7:0] string_byte();
    logic [7:0] r;
    r = 8'($urandom_range(255));
    if ((r == CH_BEL || r == CH_ESC) && $urandom_range(3) != 0) r = 8'h41;
    return r;
  endfunction

  // one random sequence into the burst; mostly well formed, some broken or cut short
  task automatic build_sequence(bit go_long);
    int sel, n;
    logic [7:0] r;
    burst.delete();
    sel = go_long ? 45 + 20 * $urandom_range(1) : $urandom_range(99);
    if (sel < 25) begin
      // plain text
      n = $urandom_range(1, 4);
      repeat (n) burst_add($urandom_range(255));
    end else if (sel < 35) begin
      // two-byte escape
      do r = 8'($urandom_range(8'h40, 8'h5F)); while (r == CH_CSI || string_intro(r));
      burst_add(CH_ESC);
      burst_add(r);
    end else if (sel < 55 || sel >= 80) begin
      // control sequence
      burst_add(CH_ESC);
      burst_add(CH_CSI);
      n = go_long ? $urandom_range(28, 34) : $urandom_range(0, 4);
      repeat (n) burst_add($urandom_range(8'h30, 8'h3F));
      repeat ($urandom_range(0, 2)) burst_add($urandom_range(8'h20, 8'h2F));
      burst_add($urandom_range(8'h40, 8'h7E));
    end else if (sel < 75) begin
      // string escape ended by bell or ESC backslash
      burst_add(CH_ESC);
      case ($urandom_range(3))
        0: burst_add(CH_OSC);
        1: burst_add(CH_DCS);
        2: burst_add(CH_PM);
        default: burst_add(CH_APC);
      endcase
      n = go_long ? $urandom_range(27, 34) : $urandom_range(0, 6);
      repeat (n) burst_add(string_byte());
      if ($urandom_range(1)) burst_add(CH_BEL);
      else begin
        burst_add(CH_ESC);
        burst_add(CH_BSL);
      end
    end else begin
      // noise, heavy on ESC
      n = $urandom_range(1, 3);
      repeat (n) burst_add(($urandom_range(9) < 3) ? CH_ESC : $urandom_range(255));
    end
    // break some sequences part way
    if (!go_long && burst.size() > 1 && $urandom_range(99) < 25) begin
      n = $urandom_range(1, burst.size() - 1);
      while (burst.size() > n) void'(burst.pop_back());
      case ($urandom_range(2))
        0: burst_add(EOS_MARK);
        1: burst_add($urandom_range(255));
        default: ;
      endcase
    end
    if ($urandom_range(99) < 6) burst_add(EOS_MARK);
  endtask

  // every escape form, terminators, failures and end of stream, no idling
  task automatic test_directed_cases();
    send_idle_pct = 0;
    stall_pct = 0;
    burst = '{8'h80,
              CH_ESC, FE_HI,
              CH_ESC, CH_CSI, PAR_LO, INT_HI, FIN_HI,
              CH_ESC, CH_OSC, 8'h00, CH_BEL,
              CH_ESC, CH_DCS, CH_ESC, CH_BSL,
              CH_ESC, CH_APC, 8'hFF, CH_ESC, 8'h63,
              CH_ESC, CH_CSI, PAR_HI, EOS_MARK,
              CH_ESC, CH_PM, CH_ESC, EOS_MARK,
              EOS_MARK};
    send_burst();
  endtask

  // long strings and control sequences that run into a full store
  task automatic test_store_full();
    send_idle_pct = 0;
    stall_pct = 31;
    repeat (4) begin
      build_sequence(1'b1);
      send_burst();
    end
  endtask

  task automatic test_random_traffic(int idle_pct, int stall, int n);
    int target;
    send_idle_pct = idle_pct;
    stall_pct = stall;
    target = items_sent + n;
    while (items_sent < target) begin
      build_sequence($urandom_range(99) < 4);
      send_burst();
    end
  endtask

  // receiver holds off while text keeps coming, so input must stall
  task automatic test_input_backpressure();
    send_idle_pct = 0;
    stall_pct = 0;
    hold_token++;
    repeat (30) send_item(1'b0, 8'($urandom_range(8'h20, 8'h7E)));
    burst = '{CH_ESC, CH_CSI, PAR_LO, 8'h00};
    send_burst();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_random_traffic(0, 0, 25);
    test_random_traffic(69, 0, 25);
    test_random_traffic(0, 69, 25);
    test_random_traffic(31, 31, 25);
    test_store_full();
    test_input_backpressure();
    test_random_traffic(0, 0, 25);

    // let the last requests drain
    in_valid <= 1'b0;
    while (expected_text.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_text.size() != 0) begin
      $display("%0t: %0d expected text bytes never arrived", $time, expected_text.size());
      errors++;
    end
    $display("%0d requests sent (%0d end of stream), %0d text bytes compared",
             items_sent, eos_sent, results_checked);
    $display("%0d escapes given up, %0d of them on a full store, %0d mismatches",
             aborts, overflow_fails, errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* ansi_escape_stripper.f */
design/esc_strip_pkg.sv
design/esc_strip_dpath.sv
design/esc_strip_ctrl.sv
design/ansi_escape_stripper.sv
bench/ansi_escape_stripper_tb.sv
